>>> src/partition_fit_allocator_core_defines.svh
// assertion macros for the partition fit allocator checker
// expects clk and rst_n in the scope where a macro is used
`ifndef PARTITION_FIT_ALLOCATOR_CORE_DEFINES_SVH
`define PARTITION_FIT_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define PFA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfa same-cycle check failed");

// next-cycle implication, off during reset
`define PFA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfa next-cycle check failed");

`endif

>>> src/pfa_pkg.sv
// shared types and constants for the partition fit allocator
// no dependencies
package pfa_pkg;

    localparam int SLOT_W     = 6;
    localparam int SIZE_W     = 16;
    localparam int PIU_W      = 7;
    localparam int POLICY_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE = 2'd1;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    typedef enum logic [POLICY_W-1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_policy_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } pfa_state_t;

    // sequencer to fit unit
    typedef struct packed {
        logic        clear;
        logic        eval;
        fit_policy_t policy;
    } fit_ctl_t;

endpackage

>>> src/pfa_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module pfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/pfa_fit_unit.sv
// shared subtract and compare unit, one table entry per cycle
// depends on pfa_pkg
module pfa_fit_unit #(
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfa_pkg::fit_ctl_t     ctl,
    input  logic [SIZE_BITS-1:0]  entry_free,
    input  logic [IDX_W-1:0]      entry_idx,
    input  logic [SIZE_BITS-1:0]  req_size,
    output logic                  found,
    output logic [IDX_W-1:0]      best_slot,
    output logic [SIZE_BITS-1:0]  best_left
);
    import pfa_pkg::*;

    logic                 found_reg;
    logic [IDX_W-1:0]     best_slot_reg;
    logic [SIZE_BITS-1:0] best_left_reg;
    logic                 fits;
    logic [SIZE_BITS-1:0] left;
    logic                 better;
    logic                 take;

    always_comb
    begin
        fits = (entry_free >= req_size);
        left = entry_free - req_size;
        unique case (ctl.policy)
            FIT_BEST:  better = (left < best_left_reg);
            FIT_WORST: better = (left > best_left_reg);
            default:   better = 1'b0;   // first fit keeps the first hit
        endcase
        take = ctl.eval && fits && (!found_reg || better);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_slot_reg <= entry_idx;
            best_left_reg <= left;
        end
    end

    assign found     = found_reg;
    assign best_slot = best_slot_reg;
    assign best_left = best_left_reg;

endmodule

>>> src/partition_fit_allocator_core.sv
// partition fit allocator top level on pfa_pkg, pfa_ram and pfa_fit_unit
// load: table write in the accept cycle, no result; request: ST_SCAN reads one entry per
// cycle over count = min(partitions_in_use, PARTITIONS) entries, ST_DRAIN, ST_FINISH (at once
// for zero), result into the output register when free; next item accepted once it is there
// rst_n (async, low) clears the config registers, sequencer and output valid
// the free-size table is not cleared and holds garbage until each partition is loaded
module partition_fit_allocator_core #(
    parameter int PARTITIONS = 64,
    parameter int SIZE_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [pfa_pkg::SLOT_W-1:0]    slot_index,
    input  logic [pfa_pkg::SIZE_W-1:0]    size_value,
    input  logic                          last_request,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          granted,
    output logic [pfa_pkg::SLOT_W-1:0]    chosen_slot,
    output logic [pfa_pkg::SIZE_W-1:0]    leftover_size,
    output logic                          batch_end
);
    import pfa_pkg::*;

    // table index width and a compare width that holds both the count and PARTITIONS
    localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CNT_W = $clog2(PARTITIONS + 1);
    localparam int CMP_W = (CNT_W > PIU_W) ? CNT_W : PIU_W;

    // configuration registers
    logic [POLICY_W-1:0] fit_policy_reg;
    logic [PIU_W-1:0]    parts_in_use_reg;

    // sequencer state
    pfa_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CMP_W-1:0]     count_reg, count_next;
    logic                 eval_valid_reg, eval_valid_next;
    logic [IDX_W-1:0]     eval_idx_reg;
    logic [SIZE_BITS-1:0] req_size_reg;
    logic                 last_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 granted_reg;
    logic [SLOT_W-1:0]    chosen_slot_reg;
    logic [SIZE_W-1:0]    leftover_reg;
    logic                 batch_end_reg;

    // handshake and datapath wires
    logic                 in_take;
    logic                 load_take;
    logic                 alloc_take;
    logic                 out_free;
    logic                 finish_go;
    logic [CMP_W-1:0]     piu_ext;
    logic [CMP_W-1:0]     count_clamped;
    logic                 scan_last;
    logic                 ram_wr_en;
    logic [IDX_W-1:0]     ram_wr_addr;
    logic [SIZE_BITS-1:0] ram_wr_data;
    logic                 ram_rd_en;
    logic [SIZE_BITS-1:0] ram_rd_data;
    fit_ctl_t             fit_ctl;
    logic                 fit_found;
    logic [IDX_W-1:0]     fit_slot;
    logic [SIZE_BITS-1:0] fit_left;

    // the user issues config writes only while idle (not enforced); the port never pushes back
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg   <= '0;
            parts_in_use_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FIT_POLICY:   fit_policy_reg   <= cfg_data[POLICY_W-1:0];
                CFG_PARTS_IN_USE: parts_in_use_reg <= cfg_data[PIU_W-1:0];
                default:          ;   // writes beyond the register list are dropped
            endcase
        end
    end

    // requests are taken only between searches; loads finish in the accept cycle
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign load_take  = in_take && (req_type == REQ_LOAD);
    assign alloc_take = in_take && (req_type == REQ_ALLOC);

    // output slot is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish_go = (state_reg == ST_FINISH) && out_free;

    // searched count clamped to the table depth
    assign piu_ext       = CMP_W'(parts_in_use_reg);
    assign count_clamped = (piu_ext > CMP_W'(PARTITIONS)) ? CMP_W'(PARTITIONS) : piu_ext;
    assign scan_last     = (CMP_W'(idx_reg) == (count_reg - CMP_W'(1)));

    // next state and sequencer outputs
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        eval_valid_next = 1'b0;
        ram_rd_en       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (alloc_take)
                begin
                    idx_next   = '0;
                    count_next = count_clamped;
                    // nothing to search: refuse straight away
                    state_next = (count_clamped == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // one table read per cycle, data lands next cycle
                ram_rd_en       = 1'b1;
                eval_valid_next = 1'b1;
                idx_next        = idx_reg + IDX_W'(1);
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last entry is evaluated in this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            eval_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            eval_valid_reg <= eval_valid_next;
        end
    end

    // scan counters and latched request, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        count_reg    <= count_next;
        eval_idx_reg <= idx_reg;
        if (alloc_take)
        begin
            req_size_reg <= SIZE_BITS'(size_value);
            last_reg     <= last_request;
        end
    end

    // table write: a load in the accept cycle, or the winner's write-back on finish
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = IDX_W'(slot_index);
        ram_wr_data = SIZE_BITS'(size_value);
        if (state_reg == ST_FINISH)
        begin
            ram_wr_en   = finish_go && fit_found;
            ram_wr_addr = fit_slot;
            ram_wr_data = fit_left;
        end
        else if (load_take)
        begin
            // loads outside the table are ignored
            ram_wr_en = (32'(slot_index) < PARTITIONS);
        end
    end

    pfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (PARTITIONS)
    ) u_free_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (ram_rd_data)
    );

    // fit unit cleared at request accept, fed one entry per cycle during the scan
    always_comb
    begin
        fit_ctl.clear  = alloc_take;
        fit_ctl.eval   = eval_valid_reg;
        fit_ctl.policy = fit_policy_t'(fit_policy_reg);
    end

    pfa_fit_unit #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_fit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (fit_ctl),
        .entry_free (ram_rd_data),
        .entry_idx  (eval_idx_reg),
        .req_size   (req_size_reg),
        .found      (fit_found),
        .best_slot  (fit_slot),
        .best_left  (fit_left)
    );

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
        begin
            granted_reg     <= fit_found;
            chosen_slot_reg <= fit_found ? SLOT_W'(fit_slot) : '0;
            leftover_reg    <= fit_found ? SIZE_W'(fit_left) : '0;
            batch_end_reg   <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign chosen_slot   = chosen_slot_reg;
    assign leftover_size = leftover_reg;
    assign batch_end     = batch_end_reg;

endmodule

>>> src/pfa_checker.sv
// port-level checks for the partition fit allocator, bound to the top level
// depends on pfa_pkg and partition_fit_allocator_core_defines.svh
`include "partition_fit_allocator_core_defines.svh"

module pfa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          req_type,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          granted,
    input logic [pfa_pkg::SLOT_W-1:0]    chosen_slot,
    input logic [pfa_pkg::SIZE_W-1:0]    leftover_size,
    input logic                          batch_end
);
    import pfa_pkg::*;

    // all result fields side by side
    logic [SLOT_W+SIZE_W+1:0] out_payload;

    assign out_payload = {granted, chosen_slot, leftover_size, batch_end};

    // a stalled result holds
    `PFA_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

    // a refusal reports zero slot and zero leftover
    `PFA_ASSERT_IMP(a_refuse_zero, out_valid && !granted, {chosen_slot, leftover_size} == '0)

    // an accepted allocation request makes the block busy
    `PFA_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall && (req_type == REQ_ALLOC), in_stall)

    // a new result is only loaded out of a busy search
    `PFA_ASSERT_IMP(a_result_from_search, $rose(out_valid), $past(in_stall))

endmodule

bind partition_fit_allocator_core pfa_checker u_pfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .granted       (granted),
    .chosen_slot   (chosen_slot),
    .leftover_size (leftover_size),
    .batch_end     (batch_end)
);

>>> tb/tb.sv
// self-checking testbench for partition_fit_allocator_core: table-driven directed requests,
// then random batches, checked against an in-bench free-size tracker or hand-written results
// depends on pfa_pkg (src/pfa_pkg.sv) and the core itself
module tb;
    import pfa_pkg::*;

    localparam int TBL_DEPTH  = 64;      // partitions in the instance under test
    localparam int SETTLE     = 4;       // a load request finishes in its accept cycle
    localparam int TAIL       = 80;      // longest scan plus margin
    localparam int RAND_ITEMS = 2000;

    // policy code three has no enum member; the core treats it as first fit
    localparam logic [POLICY_W-1:0] POLICY_THREE = 2'd3;

    // one result, in port order
    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] left;
        logic              batch_end;
    } grant_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_ALLOC
    } row_kind_t;

    // one line of the directed table
    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [SLOT_W-1:0]     slot;
        logic [SIZE_W-1:0]     size;
        logic                  last;
        bit                    typed;     // want holds a hand-written result
        grant_t                want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  req_type;
    logic [SLOT_W-1:0]     slot_index;
    logic [SIZE_W-1:0]     size_value;
    logic                  last_request;
    logic                  out_valid;
    logic                  out_stall;
    logic                  granted;
    logic [SLOT_W-1:0]     chosen_slot;
    logic [SIZE_W-1:0]     leftover_size;
    logic                  batch_end;

    // bench copy of the partition table and of the two registers
    logic [SIZE_W-1:0]   free_tbl [TBL_DEPTH];
    logic [POLICY_W-1:0] policy_cfg;
    logic [PIU_W-1:0]    parts_cfg;

    // results owed by the core, oldest first
    grant_t grant_q[$];

    // shared between the request driver and the result sink
    bit no_gaps;        // both sides run without idle cycles
    int hold_req;       // long result stall asked of the sink, in cycles

    int n_errors;
    int n_items;
    int n_loads;
    int n_reqs;
    int n_grant;
    int n_refuse;
    int n_cfg;
    int n_holds;
    int reqs_by_policy [4];

    partition_fit_allocator_core #(
        .PARTITIONS (TBL_DEPTH),
        .SIZE_BITS  (SIZE_W)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .slot_index    (slot_index),
        .size_value    (size_value),
        .last_request  (last_request),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted       (granted),
        .chosen_slot   (chosen_slot),
        .leftover_size (leftover_size),
        .batch_end     (batch_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the core hangs
    initial
    begin
        #2000000;
        $display("partition_fit_allocator_core regression: fail");
        $finish;
    end

    task automatic flag_error(input string msg);
        n_errors++;
        if (n_errors <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // search the first min(count, depth) partitions under the current policy;
    // first fit and code three keep the first hit, best and worst keep the
    // lowest index on a tie since only a strict improvement replaces the pick
    function automatic grant_t place_request(input logic [SIZE_W-1:0] need,
                                             input logic last);
        grant_t res;
        int span;
        int pick;
        bit hit;
        logic [SIZE_W-1:0] room;
        logic [SIZE_W-1:0] best_room;
        span = (parts_cfg > TBL_DEPTH) ? TBL_DEPTH : int'(parts_cfg);
        hit = 1'b0;
        pick = 0;
        best_room = '0;
        for (int k = 0; k < span; k++)
        begin
            if (free_tbl[k] >= need)
            begin
                room = free_tbl[k] - need;
                if (policy_cfg == FIT_BEST)
                begin
                    if (!hit || room < best_room)
                    begin
                        hit = 1'b1;
                        pick = k;
                        best_room = room;
                    end
                end
                else if (policy_cfg == FIT_WORST)
                begin
                    if (!hit || room > best_room)
                    begin
                        hit = 1'b1;
                        pick = k;
                        best_room = room;
                    end
                end
                else if (!hit)
                begin
                    hit = 1'b1;
                    pick = k;
                    best_room = room;
                end
            end
        end
        if (hit)
        begin
            free_tbl[pick] = best_room;
            res = '{1'b1, SLOT_W'(pick), best_room, last};
        end
        else
            res = '{1'b0, '0, '0, last};
        return res;
    endfunction

    // offer one request after a random gap (none with no_gaps) and hold it until accepted;
    // the tracker is updated at the accepting edge
    task automatic send_item(input logic kind, input logic [SLOT_W-1:0] slot,
                             input logic [SIZE_W-1:0] size, input logic last,
                             input bit typed, input grant_t want);
        int gap;
        grant_t res;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        req_type     <= kind;
        slot_index   <= slot;
        size_value   <= size;
        last_request <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        n_items++;
        if (kind == REQ_LOAD)
        begin
            // every 6-bit slot lies inside the 64-entry table
            free_tbl[slot] = size;
            n_loads++;
        end
        else
        begin
            res = place_request(size, last);
            grant_q.push_back(typed ? want : res);
            n_reqs++;
            reqs_by_policy[policy_cfg]++;
            if (res.granted)
                n_grant++;
            else
                n_refuse++;
        end
    endtask

    // drop valid, wait for every owed result, then let a trailing load finish
    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // register writes only with the core idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        quiesce();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == CFG_FIT_POLICY)
            policy_cfg = val[POLICY_W-1:0];
        else if (idx == CFG_PARTS_IN_USE)
            parts_cfg = val[PIU_W-1:0];
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random request: sizes mostly small so that fits and misses both happen,
    // loads lean toward the searched range
    task automatic send_random(input logic kind, input int span, input logic last);
        logic [SLOT_W-1:0] slot;
        logic [SIZE_W-1:0] size;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            size = '0;
        else if (pick == 1)
            size = '1;
        else if (pick == 2)
            size = SIZE_W'($urandom);
        else if (kind == REQ_LOAD)
            size = SIZE_W'($urandom_range(0, 2000));
        else
            size = SIZE_W'($urandom_range(0, 600));
        if (kind == REQ_LOAD && span > 0 && $urandom_range(0, 1) == 1)
            slot = SLOT_W'($urandom_range(0, span - 1));
        else
            slot = SLOT_W'($urandom_range(0, TBL_DEPTH - 1));
        send_item(kind, slot, size, last, 1'b0, '0);
    endtask

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        return '{ROW_CFG, idx, val, '0, '0, 1'b0, 1'b0, '0};
    endfunction

    function automatic stim_row_t item_row(input row_kind_t kind,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [SIZE_W-1:0] size,
                                           input logic last);
        return '{kind, '0, '0, slot, size, last, 1'b0, '0};
    endfunction

    function automatic stim_row_t typed_row(input logic [SIZE_W-1:0] size,
                                            input logic last, input grant_t want);
        return '{ROW_ALLOC, '0, '0, '0, size, last, 1'b1, want};
    endfunction

    // result sink: random stall per result (none with no_gaps), one long stall on demand, and an
    // in-order compare against the oldest owed result
    initial
    begin : result_sink
        int hold;
        grant_t seen;
        grant_t want;
        out_stall = 1'b0;
        forever
        begin
            if (hold_req != 0)
            begin
                // long hold-off, counted here so the driver keeps pushing
                repeat (hold_req)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
                hold_req = 0;
                n_holds++;
            end
            else
            begin
                hold = no_gaps ? 0 : $urandom_range(0, 3);
                repeat (hold)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            seen = '{granted, chosen_slot, leftover_size, batch_end};
            if (grant_q.size() == 0)
                flag_error($sformatf("unexpected result granted=%0b slot=%0d left=%0d end=%0b",
                                     seen.granted, seen.slot, seen.left, seen.batch_end));
            else
            begin
                want = grant_q.pop_front();
                if (seen.granted !== want.granted || seen.slot !== want.slot ||
                    seen.left !== want.left || seen.batch_end !== want.batch_end)
                    flag_error($sformatf({"result mismatch: expected granted=%0b slot=%0d ",
                                          "left=%0d end=%0b, got granted=%0b slot=%0d ",
                                          "left=%0d end=%0b"},
                                         want.granted, want.slot, want.left, want.batch_end,
                                         seen.granted, seen.slot, seen.left, seen.batch_end));
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t plan[$];
        int phase;
        int piu;
        int span;
        int pick;
        int stop_at;
        int n_ld;
        int n_rq;
        int rand_end;
        bit paused;

        // every input known from time zero, reset asserted first
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        req_type     = REQ_LOAD;
        slot_index   = '0;
        size_value   = '0;
        last_request = 1'b0;
        policy_cfg   = FIT_FIRST;
        parts_cfg    = '0;
        no_gaps      = 1'b0;
        hold_req     = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill the whole table so no search ever reads an unloaded partition;
        // the registers stay at their reset values meanwhile
        for (int s = 0; s < TBL_DEPTH; s++)
        begin
            if (s == TBL_DEPTH - 1)
                send_item(REQ_LOAD, SLOT_W'(s), '1, 1'b0, 1'b0, '0);
            else if (s == TBL_DEPTH - 2)
                send_item(REQ_LOAD, SLOT_W'(s), '0, 1'b1, 1'b0, '0);
            else
                send_item(REQ_LOAD, SLOT_W'(s), SIZE_W'($urandom),
                          1'($urandom_range(0, 1)), 1'b0, '0);
        end

        // directed table
        // zero partitions in use after reset: refused, marker copied
        plan.push_back(typed_row(16'd5, 1'b1, '{1'b0, 6'd0, 16'd0, 1'b1}));
        plan.push_back(cfg_row(CFG_PARTS_IN_USE, 7'd4));
        plan.push_back(item_row(ROW_LOAD, 6'd0, 16'd100, 1'b0));
        plan.push_back(item_row(ROW_LOAD, 6'd1, 16'd40, 1'b0));
        plan.push_back(item_row(ROW_LOAD, 6'd2, 16'd300, 1'b0));
        // batch marker on a load has no effect
        plan.push_back(item_row(ROW_LOAD, 6'd3, 16'd60, 1'b1));
        plan.push_back(cfg_row(CFG_FIT_POLICY, CFG_DATA_W'(FIT_FIRST)));
        plan.push_back(item_row(ROW_ALLOC, 6'd0, 16'd50, 1'b0));
        // largest size fits nowhere among 50, 40, 300, 60
        plan.push_back(typed_row(16'hFFFF, 1'b1, '{1'b0, 6'd0, 16'd0, 1'b1}));
        plan.push_back(item_row(ROW_ALLOC, 6'd0, 16'd0, 1'b0));
        plan.push_back(cfg_row(CFG_FIT_POLICY, CFG_DATA_W'(FIT_BEST)));
        plan.push_back(item_row(ROW_ALLOC, 6'd0, 16'd40, 1'b0));
        // slot index is ignored on an allocation
        plan.push_back(item_row(ROW_ALLOC, 6'd63, 16'd0, 1'b1));
        plan.push_back(cfg_row(CFG_FIT_POLICY, CFG_DATA_W'(FIT_WORST)));
        plan.push_back(item_row(ROW_ALLOC, 6'd0, 16'd10, 1'b0));
        // equal leftovers in slots 0 and 2: lowest index wins
        plan.push_back(item_row(ROW_LOAD, 6'd0, 16'd290, 1'b0));
        plan.push_back(item_row(ROW_ALLOC, 6'd0, 16'd0, 1'b1));
        plan.push_back(cfg_row(CFG_FIT_POLICY, CFG_DATA_W'(POLICY_THREE)));
        plan.push_back(item_row(ROW_ALLOC, 6'd0, 16'd1, 1'b0));
        // count above the table size searches all 64 entries
        plan.push_back(cfg_row(CFG_PARTS_IN_USE, 7'd127));
        plan.push_back(item_row(ROW_ALLOC, 6'd0, 16'hFFFF, 1'b0));
        plan.push_back(cfg_row(CFG_PARTS_IN_USE, 7'd64));
        plan.push_back(cfg_row(CFG_FIT_POLICY, CFG_DATA_W'(FIT_WORST)));
        plan.push_back(item_row(ROW_ALLOC, 6'd0, 16'd0, 1'b1));
        plan.push_back(cfg_row(CFG_PARTS_IN_USE, 7'd0));
        plan.push_back(typed_row(16'd1, 1'b1, '{1'b0, 6'd0, 16'd0, 1'b1}));
        plan.push_back(typed_row(16'd0, 1'b0, '{1'b0, 6'd0, 16'd0, 1'b0}));

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_item(plan[i].kind == ROW_ALLOC ? REQ_ALLOC : REQ_LOAD, plan[i].slot,
                          plan[i].size, plan[i].last, plan[i].typed, plan[i].want);
        end

        // random phases: fresh policy and partition count each time, then
        // batches of loads followed by allocation requests closing on the marker
        rand_end = n_items + RAND_ITEMS;
        paused = 1'b0;
        for (phase = 0; n_items < rand_end; phase++)
        begin
            pick = $urandom_range(0, 19);
            if (phase == 0 || pick == 0)
                piu = 127;
            else if (phase == 1 || pick == 1)
                piu = 0;
            else if (phase == 2 || pick == 2)
                piu = 64;
            else if (pick == 3)
                piu = $urandom_range(65, 126);
            else if (pick <= 6)
                piu = $urandom_range(9, 63);
            else
                piu = $urandom_range(1, 8);
            span = (piu > TBL_DEPTH) ? TBL_DEPTH : piu;
            write_reg(CFG_FIT_POLICY,
                      CFG_DATA_W'((phase < 4) ? phase : $urandom_range(0, 3)));
            write_reg(CFG_PARTS_IN_USE, CFG_DATA_W'(piu));

            // a few phases run flat out on both sides
            no_gaps = (phase % 7 == 3);
            // receiver sits on its stall while requests keep coming
            if (phase == 6)
                hold_req = 250;

            stop_at = n_items + $urandom_range(20, 60);
            while (n_items < stop_at)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // stray request of either kind with a random marker
                    send_random(1'($urandom_range(0, 1)), span, 1'($urandom_range(0, 1)));
                end
                else
                begin
                    n_ld = $urandom_range(0, 4);
                    n_rq = $urandom_range(1, 8);
                    repeat (n_ld)
                        send_random(REQ_LOAD, span, $urandom_range(0, 3) == 0);
                    for (int j = 0; j < n_rq; j++)
                        send_random(REQ_ALLOC, span, j == n_rq - 1);
                    // sender waits once mid-phase for every owed result
                    if (phase == 12 && !paused)
                    begin
                        quiesce();
                        paused = 1'b1;
                    end
                end
            end
        end
        no_gaps = 1'b0;

        // drain, then give a late or extra result time to show up
        @(negedge clk);
        in_valid <= 1'b0;
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (grant_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", grant_q.size()));

        $display("covered %0d loads, %0d allocations (%0d granted, %0d refused), %0d reg writes",
                 n_loads, n_reqs, n_grant, n_refuse, n_cfg);
        $display("policies first %0d, best %0d, worst %0d, code three %0d; %0d long stalls",
                 reqs_by_policy[FIT_FIRST], reqs_by_policy[FIT_BEST],
                 reqs_by_policy[FIT_WORST], reqs_by_policy[POLICY_THREE], n_holds);
        if (n_errors == 0)
            $display("partition_fit_allocator_core regression: pass");
        else
            $display("partition_fit_allocator_core regression: fail");
        $finish;
    end
endmodule
